### rtl/core/lfpc_pkg.sv
// ----------------------------------------------------------------------------
// lfpc_pkg
// Shared types and constants of the LED fade pattern controller.
// ----------------------------------------------------------------------------
package lfpc_pkg;

   localparam logic       FUNC_TICK = 1'b0;
   localparam logic       FUNC_SET  = 1'b1;

   localparam logic [2:0] PAT_OFF        = 3'd0;
   localparam logic [2:0] PAT_ON         = 3'd1;
   localparam logic [2:0] PAT_BREATHE    = 3'd2;
   localparam logic [2:0] PAT_BRIGHTNESS = 3'd3;
   localparam logic [2:0] PAT_FADE_UP    = 3'd4;
   localparam logic [2:0] PAT_FADE_DOWN  = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_APPLY,
      ST_DONE
   } lfpc_state_type;

   typedef struct packed {
      logic load_req;
      logic exec;
      logic div_step;
      logic apply;
      logic load_rsp;
   } lfpc_cmd_type;

   typedef struct packed {
      logic run;
      logic div_needed;
      logic div_last;
   } lfpc_status_type;

endpackage

### rtl/core/lfpc_ctrl.sv
// ----------------------------------------------------------------------------
// lfpc_ctrl
// Sequencer of the LED fade pattern controller: handshakes and datapath steps.
// ----------------------------------------------------------------------------
module lfpc_ctrl
   import lfpc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  lfpc_status_type status,
   output lfpc_cmd_type    cmd
);

   lfpc_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (status.run) state_in = status.div_needed ? ST_DIV : ST_APPLY;
            else state_in = ST_DONE;
         end
         ST_DIV: begin
            if (status.div_last) state_in = ST_APPLY;
         end
         ST_APPLY: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         ST_EXEC:  cmd.exec     = 1'b1;
         ST_DIV:   cmd.div_step = 1'b1;
         ST_APPLY: cmd.apply    = 1'b1;
         ST_DONE:  cmd.load_rsp = slot_free;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending transfer");

   a_accept_starts_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EXEC))
      else $error("accepted item not executed");

   a_div_ends_in_apply: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && status.div_last) |=> (state_ff == ST_APPLY))
      else $error("division did not hand over to apply");

endmodule

### rtl/core/lfpc_datapath.sv
// ----------------------------------------------------------------------------
// lfpc_datapath
// Pattern state, millisecond clock, fade step divider and result registers.
// ----------------------------------------------------------------------------
module lfpc_datapath
   import lfpc_pkg::*;
#(
   parameter int LEVEL_MAX = 255,
   parameter int FRAC_BITS = 8
)
(
   input  logic            clock,
   input  logic            reset,
   input  lfpc_cmd_type    cmd,
   output lfpc_status_type status,
   input  logic            req_func,
   input  logic [2:0]      req_pattern_request,
   input  logic [15:0]     req_first_param,
   input  logic [15:0]     req_second_param,
   input  logic [15:0]     req_elapsed_ms,
   input  logic            csr_wr_en,
   input  logic            csr_wr_data,
   output logic [7:0]      rsp_pwm_level,
   output logic            rsp_pin_state,
   output logic            rsp_pwm_active,
   output logic [2:0]      rsp_active_pattern
);

   localparam int MW   = $clog2(LEVEL_MAX + 1);
   localparam int LW   = MW + FRAC_BITS;
   localparam int NW   = LW + 16;
   localparam int SW   = FRAC_BITS + 9;
   localparam int AW   = ((LW > SW) ? LW : SW) + 1;
   localparam int CW   = (NW > FRAC_BITS + 10) ? NW : FRAC_BITS + 10;
   localparam int XW   = LW + 8;
   localparam int CNTW = $clog2(NW + 1);

   localparam logic [LW-1:0] LEVEL_TOP     = LW'(LEVEL_MAX) << FRAC_BITS;
   localparam logic [SW-1:0] ONE_UNIT      = SW'(1) << FRAC_BITS;
   localparam logic [CW-1:0] STEP_LIMIT    = CW'(256) << FRAC_BITS;
   localparam logic [CW-1:0] PIN_THRESHOLD = CW'(127) << FRAC_BITS;
   localparam logic [15:0]   LEVEL_MAX_16  = 16'(LEVEL_MAX);

   logic             func_ff, func_in;
   logic [2:0]       request_ff, request_in;
   logic [15:0]      p1_ff, p1_in;
   logic [15:0]      p2_ff, p2_in;
   logic [15:0]      dt_ff, dt_in;

   logic             pwm_en_ff, pwm_en_in;
   logic [LW-1:0]    level_ff, level_in;
   logic [2:0]       pattern_ff, pattern_in;
   logic [2:0]       last_ff, last_in;
   logic             breathe_ff, breathe_in;
   logic [15:0]      rise_ff, rise_in;
   logic [15:0]      fall_ff, fall_in;
   logic [15:0]      dur_ff, dur_in;
   logic [31:0]      clk_ff, clk_in;
   logic [31:0]      end_ff, end_in;

   logic [NW-1:0]    num_ff, num_in;
   logic [15:0]      rem_ff, rem_in;
   logic [CNTW-1:0]  cnt_ff, cnt_in;

   logic [7:0]       pwm_level_ff, pwm_level_in;
   logic             pin_ff, pin_in;
   logic             active_ff, active_in;
   logic [2:0]       act_pat_ff, act_pat_in;

   logic [31:0]      clk_sum;
   logic             fading;
   logic             before_end;
   logic             restart;
   logic [15:0]      bright_val;
   logic [15:0]      fall_dur;
   logic [NW-1:0]    product;
   logic [16:0]      rem_sh;
   logic [16:0]      rem_diff;
   logic             q_bit;
   logic [SW-1:0]    step;
   logic [AW-1:0]    up_sum;
   logic [XW-1:0]    level_ext;

   assign clk_sum    = clk_ff + 32'(dt_ff);
   assign fading     = (pattern_ff == PAT_FADE_UP) || (pattern_ff == PAT_FADE_DOWN);
   assign before_end = clk_sum < end_ff;
   assign restart    = (request_ff != last_ff) || (request_ff == PAT_BRIGHTNESS);
   assign bright_val = (p1_ff > LEVEL_MAX_16) ? LEVEL_MAX_16 : p1_ff;
   assign fall_dur   = (fall_ff != 16'd0) ? fall_ff : rise_ff;
   assign product    = NW'(LEVEL_TOP) * NW'(dt_ff);
   assign rem_sh     = {rem_ff, num_ff[NW-1]};
   assign rem_diff   = rem_sh - {1'b0, dur_ff};
   assign q_bit      = !rem_diff[16];
   assign up_sum     = AW'(level_ff) + AW'(step);
   assign level_ext  = XW'(level_ff);

   always_comb begin
      if (dur_ff == 16'd0 || CW'(num_ff) > STEP_LIMIT) step = ONE_UNIT;
      else step = SW'(num_ff);
   end

   assign status.run        = (func_ff == FUNC_TICK) && fading && before_end;
   assign status.div_needed = dur_ff != 16'd0;
   assign status.div_last   = cnt_ff == CNTW'(1);

   always_comb begin
      func_in      = func_ff;
      request_in   = request_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      dt_in        = dt_ff;
      pwm_en_in    = csr_wr_en ? csr_wr_data : pwm_en_ff;
      level_in     = level_ff;
      pattern_in   = pattern_ff;
      last_in      = last_ff;
      breathe_in   = breathe_ff;
      rise_in      = rise_ff;
      fall_in      = fall_ff;
      dur_in       = dur_ff;
      clk_in       = clk_ff;
      end_in       = end_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      pwm_level_in = pwm_level_ff;
      pin_in       = pin_ff;
      active_in    = active_ff;
      act_pat_in   = act_pat_ff;

      if (cmd.load_req) begin
         func_in    = req_func;
         request_in = req_pattern_request;
         p1_in      = req_first_param;
         p2_in      = req_second_param;
         dt_in      = req_elapsed_ms;
      end

      if (cmd.exec) begin
         if (func_ff == FUNC_SET) begin
            rise_in = p1_ff;
            fall_in = p2_ff;
            if (restart) begin
               last_in    = request_ff;
               breathe_in = request_ff == PAT_BREATHE;
               dur_in     = p1_ff;
               end_in     = clk_ff + 32'(p1_ff);
               unique case (request_ff)
                  PAT_OFF: begin
                     pattern_in = PAT_OFF;
                     level_in   = '0;
                  end
                  PAT_BREATHE, PAT_FADE_UP: begin
                     pattern_in = PAT_FADE_UP;
                     level_in   = '0;
                  end
                  PAT_BRIGHTNESS: begin
                     pattern_in = PAT_BRIGHTNESS;
                     if (p2_ff != 16'd0) level_in = '0;
                     else level_in = LW'(bright_val) << FRAC_BITS;
                  end
                  PAT_FADE_DOWN: begin
                     pattern_in = PAT_FADE_DOWN;
                     level_in   = LEVEL_TOP;
                  end
                  default: begin
                     pattern_in = PAT_ON;
                     level_in   = LEVEL_TOP;
                  end
               endcase
            end
         end else begin
            clk_in = clk_sum;
            num_in = product;
            rem_in = '0;
            cnt_in = CNTW'(NW);
            if (fading && !before_end) begin
               if (pattern_ff == PAT_FADE_UP) begin
                  level_in = LEVEL_TOP;
                  if (breathe_ff) begin
                     pattern_in = PAT_FADE_DOWN;
                     dur_in     = fall_dur;
                     end_in     = clk_sum + 32'(fall_dur);
                  end
               end else begin
                  level_in = '0;
                  if (breathe_ff) begin
                     pattern_in = PAT_FADE_UP;
                     dur_in     = rise_ff;
                     end_in     = clk_sum + 32'(rise_ff);
                  end
               end
            end
         end
      end

      if (cmd.div_step) begin
         rem_in = q_bit ? rem_diff[15:0] : rem_sh[15:0];
         num_in = {num_ff[NW-2:0], q_bit};
         cnt_in = cnt_ff - CNTW'(1);
      end

      if (cmd.apply) begin
         if (pattern_ff == PAT_FADE_UP) begin
            if (up_sum > AW'(LEVEL_TOP)) level_in = LEVEL_TOP;
            else level_in = LW'(up_sum);
         end else begin
            if (AW'(level_ff) < AW'(step)) level_in = '0;
            else level_in = LW'(AW'(level_ff) - AW'(step));
         end
      end

      if (cmd.load_rsp) begin
         pwm_level_in = level_ext[FRAC_BITS +: 8];
         pin_in       = CW'(level_ff) > PIN_THRESHOLD;
         active_in    = pwm_en_ff;
         act_pat_in   = pattern_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_en_ff  <= 1'b0;
         level_ff   <= '0;
         pattern_ff <= PAT_OFF;
         last_ff    <= PAT_OFF;
         breathe_ff <= 1'b0;
         rise_ff    <= '0;
         fall_ff    <= '0;
         dur_ff     <= '0;
         clk_ff     <= '0;
         end_ff     <= '0;
         cnt_ff     <= '0;
      end else begin
         pwm_en_ff  <= pwm_en_in;
         level_ff   <= level_in;
         pattern_ff <= pattern_in;
         last_ff    <= last_in;
         breathe_ff <= breathe_in;
         rise_ff    <= rise_in;
         fall_ff    <= fall_in;
         dur_ff     <= dur_in;
         clk_ff     <= clk_in;
         end_ff     <= end_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      request_ff   <= request_in;
      p1_ff        <= p1_in;
      p2_ff        <= p2_in;
      dt_ff        <= dt_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      pwm_level_ff <= pwm_level_in;
      pin_ff       <= pin_in;
      active_ff    <= active_in;
      act_pat_ff   <= act_pat_in;
   end

   assign rsp_pwm_level      = pwm_level_ff;
   assign rsp_pin_state      = pin_ff;
   assign rsp_pwm_active     = active_ff;
   assign rsp_active_pattern = act_pat_ff;

   a_level_in_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LEVEL_TOP)
      else $error("level above full scale");

   a_count_down: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (cnt_ff != '0))
      else $error("divider stepped past its last bit");

   a_pattern_valid: assert property (@(posedge clock) disable iff (reset)
      pattern_ff <= PAT_FADE_DOWN && pattern_ff != PAT_BREATHE)
      else $error("breathing stored as a running pattern");

endmodule

### rtl/core/led_fade_pattern_controller.sv
// ----------------------------------------------------------------------------
// led_fade_pattern_controller
// LED brightness pattern engine with fades, breathing and a millisecond clock.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                   Payload
//  req      in         req_valid / req_ready       func, pattern_request, params, elapsed
//  rsp      out        rsp_valid / rsp_ready       pwm_level, pin_state, pwm_active, pattern
//  csr      in         csr_wr_en, no wait          pwm_output_enable
//
//  A set item, or a tick that ends a fade or lies outside one, passes through
//  transfer, execute and result load. A running fade tick adds the steps of the
//  one-bit-per-cycle restoring divider and an apply step before the result load,
//  or only the apply step when the fade duration is zero. One item is in work at a time;
//  the next is taken while a result waits, and a stalled result holds the
//  sequencer in its final step. Reset clears the pattern state, clock and enable.
// ----------------------------------------------------------------------------
module led_fade_pattern_controller
   import lfpc_pkg::*;
#(
   parameter int LEVEL_MAX = 255,
   parameter int FRAC_BITS = 8
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [2:0]  req_pattern_request,
   input  logic [15:0] req_first_param,
   input  logic [15:0] req_second_param,
   input  logic [15:0] req_elapsed_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_pwm_level,
   output logic        rsp_pin_state,
   output logic        rsp_pwm_active,
   output logic [2:0]  rsp_active_pattern,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   lfpc_cmd_type    cmd;
   lfpc_status_type status;

   lfpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lfpc_datapath #(
      .LEVEL_MAX (LEVEL_MAX),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_func            (req_func),
      .req_pattern_request (req_pattern_request),
      .req_first_param     (req_first_param),
      .req_second_param    (req_second_param),
      .req_elapsed_ms      (req_elapsed_ms),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_pwm_level       (rsp_pwm_level),
      .rsp_pin_state       (rsp_pin_state),
      .rsp_pwm_active      (rsp_pwm_active),
      .rsp_active_pattern  (rsp_active_pattern)
   );

endmodule

### verif/tb_led_fade_pattern_controller.sv
// ----------------------------------------------------------------------------
// tb_led_fade_pattern_controller
// Self-checking testbench of the LED fade pattern controller.
//
// A table of directed items covers the pattern codes, parameter extremes and
// fade endings, then short fades are stepped and overrun, and random pattern
// and tick bursts follow with the PWM enable on, off, then on. Every result
// is checked against its typed table value or a behavioral model of the
// level, clock and pattern state in this module. Both channels idle at random,
// and once the result side holds off long enough to back up the request side.
// ----------------------------------------------------------------------------
module tb_led_fade_pattern_controller;
   import lfpc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LEVEL_MAX = 255;
   localparam int FRAC_BITS = 8;
   localparam logic [63:0] LEVEL_TOP     = 64'(LEVEL_MAX) << FRAC_BITS;
   localparam logic [63:0] ONE_UNIT      = 64'd1 << FRAC_BITS;
   localparam logic [63:0] STEP_LIMIT    = 64'd256 << FRAC_BITS;
   localparam logic [63:0] PIN_THRESHOLD = 64'd127 << FRAC_BITS;

   localparam logic [2:0]  PAT_SPARE_LO = 3'd6;
   localparam logic [2:0]  PAT_SPARE_HI = 3'd7;

   localparam int          RANDOM_ITEMS     = 660;
   localparam int          LONG_HOLD_CYCLES = 400;
   localparam int          DRAIN_CYCLES     = 60;
   localparam int          CYCLE_LIMIT      = 4_000_000;

   typedef struct packed {
      logic [7:0] level;
      logic       pin;
      logic       active;
      logic [2:0] pattern;
   } led_result_type;

   typedef struct {
      logic           func;
      logic [2:0]     req;
      logic [15:0]    p1;
      logic [15:0]    p2;
      logic [15:0]    dt;
      bit             typed;
      led_result_type want;
   } led_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = 1'b0;
   logic [2:0]  req_pattern_request = '0;
   logic [15:0] req_first_param = '0;
   logic [15:0] req_second_param = '0;
   logic [15:0] req_elapsed_ms = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_pwm_level;
   logic        rsp_pin_state;
   logic        rsp_pwm_active;
   logic [2:0]  rsp_active_pattern;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;

   // Model state of the pattern engine.
   logic [63:0] lvl_q = '0;
   logic [2:0]  pat_q = PAT_OFF;
   logic [2:0]  last_req_q = PAT_OFF;
   logic        breathe_q = 1'b0;
   logic [15:0] rise_q = '0;
   logic [15:0] fall_q = '0;
   logic [15:0] dur_q = '0;
   logic [31:0] now_q = '0;
   logic [31:0] end_q = '0;
   logic        pwm_en_q = 1'b0;

   led_result_type expected_levels_q[$];
   led_row_type    directed_rows[$];
   int          error_count = 0;
   int          item_count = 0;
   int          cycle_count = 0;
   bit          tx_gaps = 1'b1;
   bit          rx_gaps = 1'b1;
   bit          hold_request = 1'b0;

   led_fade_pattern_controller #(
      .LEVEL_MAX(LEVEL_MAX),
      .FRAC_BITS(FRAC_BITS)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_pattern_request(req_pattern_request),
      .req_first_param    (req_first_param),
      .req_second_param   (req_second_param),
      .req_elapsed_ms     (req_elapsed_ms),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pwm_level      (rsp_pwm_level),
      .rsp_pin_state      (rsp_pin_state),
      .rsp_pwm_active     (rsp_pwm_active),
      .rsp_active_pattern (rsp_active_pattern),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic [63:0] fade_increment(input logic [15:0] dt);
      logic [63:0] quotient;
      if (dur_q == 16'd0) return ONE_UNIT;
      quotient = (LEVEL_TOP * 64'(dt)) / 64'(dur_q);
      return (quotient > STEP_LIMIT) ? ONE_UNIT : quotient;
   endfunction

   function automatic led_result_type advance_led_state(input logic func, input logic [2:0] req,
                                                        input logic [15:0] p1, p2, dt);
      logic [63:0] inc;
      led_result_type res;
      if (func == FUNC_SET) begin
         rise_q = p1;
         fall_q = p2;
         if (req != last_req_q || req == PAT_BRIGHTNESS) begin
            last_req_q = req;
            breathe_q = (req == PAT_BREATHE);
            pat_q = breathe_q ? PAT_FADE_UP : req;
            case (pat_q)
               PAT_OFF, PAT_FADE_UP: lvl_q = '0;
               PAT_BRIGHTNESS: begin
                  if (p2 != 16'd0) lvl_q = '0;
                  else lvl_q = ((p1 > LEVEL_MAX) ? 64'(LEVEL_MAX) : 64'(p1)) << FRAC_BITS;
               end
               PAT_ON, PAT_FADE_DOWN: lvl_q = LEVEL_TOP;
               default: begin
                  pat_q = PAT_ON;
                  lvl_q = LEVEL_TOP;
               end
            endcase
            dur_q = p1;
            end_q = now_q + 32'(p1);
         end
      end else begin
         now_q = now_q + 32'(dt);
         if (pat_q == PAT_FADE_UP) begin
            if (now_q < end_q) begin
               inc = fade_increment(dt);
               lvl_q = (LEVEL_TOP - lvl_q < inc) ? LEVEL_TOP : lvl_q + inc;
            end else begin
               lvl_q = LEVEL_TOP;
               if (breathe_q) begin
                  pat_q = PAT_FADE_DOWN;
                  dur_q = (fall_q != 16'd0) ? fall_q : rise_q;
                  end_q = now_q + 32'(dur_q);
               end
            end
         end else if (pat_q == PAT_FADE_DOWN) begin
            if (now_q < end_q) begin
               inc = fade_increment(dt);
               lvl_q = (lvl_q < inc) ? 64'd0 : lvl_q - inc;
            end else begin
               lvl_q = '0;
               if (breathe_q) begin
                  pat_q = PAT_FADE_UP;
                  dur_q = rise_q;
                  end_q = now_q + 32'(dur_q);
               end
            end
         end
      end
      if (lvl_q > LEVEL_TOP) lvl_q = LEVEL_TOP;
      res.level = 8'(lvl_q >> FRAC_BITS);
      res.pin = (lvl_q > PIN_THRESHOLD);
      res.active = pwm_en_q;
      res.pattern = pat_q;
      return res;
   endfunction

   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 88) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] rand_span();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) return 16'($urandom_range(0, 60));
      if (pick < 9) return 16'($urandom_range(0, 2000));
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] rand_elapsed(input logic [15:0] span);
      int unsigned reach;
      int pick;
      pick = $urandom_range(0, 9);
      reach = 32'(span) + 32'(span) / 2 + 2;
      if (reach > 65535) reach = 65535;
      if (pick < 6) return 16'($urandom_range(0, 32'(span) / 4 + 2));
      if (pick < 8) return 16'($urandom_range(0, reach));
      if (pick == 8) return 16'($urandom);
      return 16'd0;
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   task automatic add_row(input bit typed, input logic func, input logic [2:0] req,
                          input logic [15:0] p1, p2, dt,
                          input logic [7:0] lvl, input logic pin, input logic [2:0] pat);
      led_row_type row;
      row.func = func;
      row.req = req;
      row.p1 = p1;
      row.p2 = p2;
      row.dt = dt;
      row.typed = typed;
      row.want.level = lvl;
      row.want.pin = pin;
      row.want.active = 1'b0;
      row.want.pattern = pat;
      directed_rows.push_back(row);
   endtask

   task automatic send_item(input logic func, input logic [2:0] req,
                            input logic [15:0] p1, p2, dt,
                            input bit typed, input led_result_type want);
      led_result_type predicted;
      int idle;
      @(negedge clock);
      req_valid <= 1'b1;
      req_func <= func;
      req_pattern_request <= req;
      req_first_param <= p1;
      req_second_param <= p2;
      req_elapsed_ms <= dt;
      do @(posedge clock); while (!req_ready);
      predicted = advance_led_state(func, req, p1, p2, dt);
      expected_levels_q.push_back(typed ? want : predicted);
      item_count++;
      idle = tx_gaps ? idle_length() : 0;
      if (idle != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (idle - 1) @(negedge clock);
      end
   endtask

   task automatic send_set(input logic [2:0] req, input logic [15:0] p1, p2);
      send_item(FUNC_SET, req, p1, p2, 16'($urandom), 1'b0, '0);
   endtask

   task automatic send_tick(input logic [15:0] dt);
      send_item(FUNC_TICK, 3'($urandom), 16'($urandom), 16'($urandom), dt, 1'b0, '0);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_levels_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_pwm_enable(input logic enable);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= enable;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      pwm_en_q = enable;
   endtask

   task automatic run_random(input int count);
      int first;
      int pick;
      logic [2:0]  req;
      logic [15:0] p1;
      logic [15:0] p2;
      first = item_count;
      while (item_count - first < count) begin
         tx_gaps = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 19) == 0) begin
            send_item(1'($urandom_range(0, 1)), 3'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom), 1'b0, '0);
         end else begin
            pick = $urandom_range(0, 15);
            if (pick < 5) req = PAT_BREATHE;
            else if (pick < 8) req = PAT_FADE_UP;
            else if (pick < 11) req = PAT_FADE_DOWN;
            else if (pick < 13) req = PAT_BRIGHTNESS;
            else req = 3'($urandom_range(0, 7));
            if (req == PAT_BRIGHTNESS) begin
               p1 = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
               p2 = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd0;
            end else begin
               p1 = rand_span();
               p2 = ($urandom_range(0, 2) == 0) ? 16'd0 : rand_span();
            end
            send_set(req, p1, p2);
            repeat ($urandom_range(1, 12)) send_tick(rand_elapsed((p1 > p2) ? p1 : p2));
         end
      end
   endtask

   initial begin
      int hold;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 149) == 0) rx_gaps = !rx_gaps;
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
            rsp_ready <= 1'b1;
         end else begin
            hold = rx_gaps ? idle_length() : 0;
            if (hold == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               repeat (hold) @(negedge clock);
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      led_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_levels_q.size() == 0) begin
            report_error($sformatf("result with nothing pending: level %0d pattern %0d",
                                   rsp_pwm_level, rsp_active_pattern));
         end else begin
            want = expected_levels_q.pop_front();
            if (rsp_pwm_level !== want.level)
               report_error($sformatf("pwm_level %0d, want %0d", rsp_pwm_level, want.level));
            if (rsp_pin_state !== want.pin)
               report_error($sformatf("pin_state %0b, want %0b", rsp_pin_state, want.pin));
            if (rsp_pwm_active !== want.active)
               report_error($sformatf("pwm_active %0b, want %0b", rsp_pwm_active, want.active));
            if (rsp_active_pattern !== want.pattern)
               report_error($sformatf("active_pattern %0d, want %0d",
                                      rsp_active_pattern, want.pattern));
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles with %0d results pending",
               cycle_count, expected_levels_q.size());
      $display("Some tests failed");
      $finish;
   end

   initial begin
      add_row(1, FUNC_TICK, PAT_OFF, 16'd0, 16'd0, 16'd0, 8'd0, 1'b0, PAT_OFF);
      add_row(1, FUNC_SET, PAT_OFF, 16'hFFFF, 16'hFFFF, 16'd0, 8'd0, 1'b0, PAT_OFF);
      add_row(1, FUNC_SET, PAT_ON, 16'd0, 16'd0, 16'd0, 8'd255, 1'b1, PAT_ON);
      add_row(1, FUNC_SET, PAT_BRIGHTNESS, 16'hFFFF, 16'd0, 16'd0, 8'd255, 1'b1, PAT_BRIGHTNESS);
      add_row(1, FUNC_SET, PAT_BRIGHTNESS, 16'd128, 16'd0, 16'd0, 8'd128, 1'b1, PAT_BRIGHTNESS);
      add_row(1, FUNC_SET, PAT_BRIGHTNESS, 16'd127, 16'd0, 16'd0, 8'd127, 1'b0, PAT_BRIGHTNESS);
      add_row(1, FUNC_SET, PAT_BRIGHTNESS, 16'd200, 16'hFFFF, 16'd0, 8'd0, 1'b0, PAT_BRIGHTNESS);
      add_row(1, FUNC_SET, PAT_SPARE_LO, 16'd0, 16'd0, 16'd0, 8'd255, 1'b1, PAT_ON);
      add_row(1, FUNC_SET, PAT_SPARE_HI, 16'd0, 16'd0, 16'd0, 8'd255, 1'b1, PAT_ON);
      add_row(1, FUNC_SET, PAT_SPARE_HI, 16'd5, 16'd0, 16'd0, 8'd255, 1'b1, PAT_ON);
      add_row(1, FUNC_SET, PAT_FADE_UP, 16'd1000, 16'd0, 16'd0, 8'd0, 1'b0, PAT_FADE_UP);
      add_row(0, FUNC_TICK, PAT_OFF, 16'd0, 16'd0, 16'd100, 8'd0, 1'b0, PAT_OFF);
      add_row(1, FUNC_TICK, PAT_OFF, 16'd0, 16'd0, 16'hFFFF, 8'd255, 1'b1, PAT_FADE_UP);
      add_row(1, FUNC_SET, PAT_FADE_DOWN, 16'hFFFF, 16'd0, 16'd0, 8'd255, 1'b1, PAT_FADE_DOWN);
      add_row(0, FUNC_TICK, PAT_OFF, 16'd0, 16'd0, 16'd1, 8'd0, 1'b0, PAT_OFF);
      add_row(1, FUNC_TICK, PAT_OFF, 16'd0, 16'd0, 16'hFFFF, 8'd0, 1'b0, PAT_FADE_DOWN);
      add_row(1, FUNC_SET, PAT_BREATHE, 16'd10, 16'd0, 16'd0, 8'd0, 1'b0, PAT_FADE_UP);
      add_row(0, FUNC_TICK, PAT_OFF, 16'd0, 16'd0, 16'd3, 8'd0, 1'b0, PAT_OFF);
      add_row(1, FUNC_TICK, PAT_OFF, 16'd0, 16'd0, 16'hFFFF, 8'd255, 1'b1, PAT_FADE_DOWN);
      add_row(0, FUNC_TICK, PAT_OFF, 16'd0, 16'd0, 16'd5, 8'd0, 1'b0, PAT_OFF);
      add_row(1, FUNC_TICK, PAT_OFF, 16'd0, 16'd0, 16'hFFFF, 8'd0, 1'b0, PAT_FADE_UP);
      add_row(0, FUNC_SET, PAT_BREATHE, 16'd1, 16'hFFFF, 16'd0, 8'd0, 1'b0, PAT_OFF);
      add_row(0, FUNC_TICK, PAT_OFF, 16'd0, 16'd0, 16'hFFFF, 8'd0, 1'b0, PAT_OFF);
      add_row(0, FUNC_TICK, PAT_OFF, 16'd0, 16'd0, 16'hFFFF, 8'd0, 1'b0, PAT_OFF);
      add_row(1, FUNC_SET, PAT_FADE_UP, 16'd0, 16'd0, 16'd0, 8'd0, 1'b0, PAT_FADE_UP);
      add_row(1, FUNC_TICK, PAT_OFF, 16'd0, 16'd0, 16'd0, 8'd255, 1'b1, PAT_FADE_UP);
      add_row(1, FUNC_SET, PAT_OFF, 16'd0, 16'd0, 16'd0, 8'd0, 1'b0, PAT_OFF);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].func, directed_rows[i].req, directed_rows[i].p1,
                   directed_rows[i].p2, directed_rows[i].dt, directed_rows[i].typed,
                   directed_rows[i].want);

      // A short fade is stepped and then overrun by a long tick.
      set_pwm_enable(1'b1);
      send_set(PAT_FADE_UP, 16'd50, 16'd0);
      send_tick(16'd20);
      send_tick(16'd300);
      send_tick(16'd100);

      hold_request = 1'b1;
      run_random(RANDOM_ITEMS / 3);
      set_pwm_enable(1'b0);
      run_random(RANDOM_ITEMS / 3);

      // A zero-length fade ends at its first tick.
      send_set(PAT_OFF, 16'd0, 16'd0);
      send_set(PAT_FADE_DOWN, 16'd0, 16'd0);
      send_tick(16'd300);
      send_tick(16'hFFFF);
      send_tick(16'd7);

      set_pwm_enable(1'b1);
      run_random(RANDOM_ITEMS / 3);
      drain_results();

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
